@@ sv/ip_range_whitelist_classifier_defines.svh @@
// Assertion macros used by the whitelist classifier datapath.
`ifndef IP_RANGE_WHITELIST_CLASSIFIER_DEFINES_SVH
`define IP_RANGE_WHITELIST_CLASSIFIER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define IPRWL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset
`define IPRWL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define IPRWL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define IPRWL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

@@ sv/iprwl_pkg.sv @@
// Types and constants shared by the whitelist classifier controller and datapath.
package iprwl_pkg;

    // Stream widths
    localparam int S_TDATA_W = 144;
    localparam int S_TUSER_W = 6;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 4;

    // Request codes
    localparam logic [1:0] REQ_CLASSIFY = 2'd0;
    localparam logic [1:0] REQ_CLEAR    = 2'd1;
    localparam logic [1:0] REQ_APPEND   = 2'd2;

    // List selectors
    localparam logic [1:0] LIST_TCP  = 2'd0;
    localparam logic [1:0] LIST_UDP  = 2'd1;
    localparam logic [1:0] LIST_DHCP = 2'd2;

    // Packet kinds and verdicts
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_TCP  = 3'd1;
    localparam logic [2:0] KIND_UDP  = 3'd2;
    localparam logic [2:0] KIND_DHCP = 3'd3;
    localparam logic [2:0] KIND_ARP  = 3'd4;

    // UDP remote address is reported as a /24
    localparam logic [31:0] UDP_NET_MASK = 32'hFFFF_FF00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // latch the incoming request, restart the scan
        logic scan;     // advance the range scan one entry
        logic exec;     // apply clear or append
        logic emit;     // load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_classify;
        logic scan_done;
        logic out_busy;
    } status_t;

endpackage

@@ sv/iprwl_ctrl.sv @@
// Request sequencer for the whitelist classifier.
module iprwl_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  iprwl_pkg::status_t status,
    output iprwl_pkg::cmd_t    cmd
);
    import iprwl_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // no request is taken while reset is held
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = status.is_classify ? ST_FINISH : ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!status.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/iprwl_dp.sv @@
// Range tables, list counts, range scan and result register.
`include "ip_range_whitelist_classifier_defines.svh"

module iprwl_dp #(
    parameter int N = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [iprwl_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [iprwl_pkg::S_TUSER_W-1:0]  s_tuser,
    input  iprwl_pkg::cmd_t                  cmd,
    output iprwl_pkg::status_t               status,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [iprwl_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [iprwl_pkg::M_TUSER_W-1:0]  m_tuser
);
    import iprwl_pkg::*;

    localparam int IDX_W     = (N > 1) ? $clog2(N) : 1;
    localparam int CNT_W     = $clog2(N + 1);
    localparam int ADDR_W    = IDX_W + 2;
    localparam int MEM_DEPTH = 3 * (2 ** IDX_W);

    // Latched request
    logic [1:0]  req_type_reg;
    logic [1:0]  list_sel_reg;
    logic [31:0] range_start_reg;
    logic [31:0] range_end_reg;
    logic        parse_ok_reg;
    logic [2:0]  pkt_kind_reg;
    logic [31:0] src_ip_reg;
    logic [31:0] remote_ip_reg;
    logic [7:0]  proto_type_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_type_reg    <= s_tuser[1:0];
            parse_ok_reg    <= s_tuser[2];
            pkt_kind_reg    <= s_tuser[5:3];
            list_sel_reg    <= s_tdata[1:0];
            range_start_reg <= s_tdata[33:2];
            range_end_reg   <= s_tdata[65:34];
            src_ip_reg      <= s_tdata[97:66];
            remote_ip_reg   <= s_tdata[129:98];
            proto_type_reg  <= s_tdata[137:130];
        end
    end

    // List counts
    logic [CNT_W-1:0] tcp_cnt_reg;
    logic [CNT_W-1:0] udp_cnt_reg;
    logic [CNT_W-1:0] dhcp_cnt_reg;
    logic [CNT_W-1:0] sel_cnt;
    logic             sel_ok;
    logic             append_ok;
    logic             do_clear;
    logic             do_append;

    always_comb begin
        case (list_sel_reg)
            LIST_TCP:  sel_cnt = tcp_cnt_reg;
            LIST_UDP:  sel_cnt = udp_cnt_reg;
            LIST_DHCP: sel_cnt = dhcp_cnt_reg;
            default:   sel_cnt = '0;
        endcase
        sel_ok    = list_sel_reg inside {LIST_TCP, LIST_UDP, LIST_DHCP};
        append_ok = sel_ok && (sel_cnt < CNT_W'(N));
        do_clear  = cmd.exec && (req_type_reg == REQ_CLEAR) && sel_ok;
        do_append = cmd.exec && (req_type_reg == REQ_APPEND) && append_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcp_cnt_reg  <= '0;
            udp_cnt_reg  <= '0;
            dhcp_cnt_reg <= '0;
        end else if (do_clear || do_append) begin
            case (list_sel_reg)
                LIST_TCP:  tcp_cnt_reg  <= do_clear ? '0 : tcp_cnt_reg + 1'b1;
                LIST_UDP:  udp_cnt_reg  <= do_clear ? '0 : udp_cnt_reg + 1'b1;
                LIST_DHCP: dhcp_cnt_reg <= do_clear ? '0 : dhcp_cnt_reg + 1'b1;
                default:   ;
            endcase
        end
    end

    // Load status for the result
    logic load_ok_reg;

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            load_ok_reg <= (req_type_reg == REQ_CLEAR) ? sel_ok : append_ok;
        end
    end

    // Which list a classify request scans
    logic             scan_en;
    logic [1:0]       scan_list;
    logic [CNT_W-1:0] scan_cnt;
    logic [31:0]      chk_ip;

    always_comb begin
        scan_en   = (req_type_reg == REQ_CLASSIFY) && parse_ok_reg;
        scan_list = LIST_TCP;
        scan_cnt  = '0;
        case (pkt_kind_reg)
            KIND_TCP: begin
                scan_list = LIST_TCP;
                scan_cnt  = scan_en ? tcp_cnt_reg : '0;
            end
            KIND_UDP: begin
                scan_list = LIST_UDP;
                scan_cnt  = scan_en ? udp_cnt_reg : '0;
            end
            KIND_DHCP: begin
                scan_list = LIST_DHCP;
                scan_cnt  = scan_en ? dhcp_cnt_reg : '0;
            end
            default: ;
        endcase
        chk_ip = (pkt_kind_reg == KIND_TCP) ? src_ip_reg : remote_ip_reg;
    end

    // Scan control: one read issued per cycle, compared in the cycle after
    logic [CNT_W-1:0] idx_reg;
    logic             rd_vld_reg;
    logic             hit_reg;
    logic [63:0]      rd_data_reg;
    logic             issue;
    logic             match;

    assign issue = cmd.scan && (idx_reg < scan_cnt) && !hit_reg;
    assign match = rd_vld_reg && (chk_ip >= rd_data_reg[63:32])
                   && (chk_ip <= rd_data_reg[31:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end else if (cmd.accept) begin
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end else begin
            rd_vld_reg <= issue;
            if (issue) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (match) begin
                hit_reg <= 1'b1;
            end
        end
    end

    // Range memory: {list, index} addressing, start in the upper word
    logic [63:0]       range_mem [0:MEM_DEPTH-1];
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign wr_addr = {list_sel_reg, sel_cnt[IDX_W-1:0]};
    assign rd_addr = {scan_list, idx_reg[IDX_W-1:0]};

    always_ff @(posedge aclk) begin
        if (do_append) begin
            range_mem[wr_addr] <= {range_start_reg, range_end_reg};
        end
        if (issue) begin
            rd_data_reg <= range_mem[rd_addr];
        end
    end

    // Result fields
    logic [2:0]  verdict;
    logic        whitelisted;
    logic [31:0] reported_ip;
    logic [55:0] station_id;
    logic        id_valid;
    logic        load_ok;
    logic [31:0] masked_ip;

    assign masked_ip = remote_ip_reg & UDP_NET_MASK;

    always_comb begin
        verdict     = KIND_NONE;
        whitelisted = 1'b0;
        reported_ip = '0;
        station_id  = '0;
        id_valid    = 1'b0;
        load_ok     = 1'b0;
        case (req_type_reg)
            REQ_CLASSIFY: begin
                if (parse_ok_reg) begin
                    case (pkt_kind_reg)
                        KIND_TCP, KIND_UDP, KIND_DHCP: begin
                            if (hit_reg) begin
                                whitelisted = 1'b1;
                            end else begin
                                verdict = pkt_kind_reg;
                                if (pkt_kind_reg == KIND_UDP) begin
                                    reported_ip = masked_ip;
                                    station_id  = {proto_type_reg, masked_ip[7:0],
                                                   masked_ip[15:8], masked_ip[23:16],
                                                   masked_ip[31:24], 16'h0000};
                                    id_valid    = 1'b1;
                                end else begin
                                    reported_ip = remote_ip_reg;
                                end
                            end
                        end
                        KIND_ARP: begin
                            verdict     = KIND_ARP;
                            reported_ip = remote_ip_reg;
                        end
                        default: ;
                    endcase
                end
            end
            REQ_CLEAR, REQ_APPEND: begin
                load_ok = load_ok_reg;
            end
            default: ;
        endcase
    end

    // Result register
    logic        out_valid_reg;
    logic [2:0]  verdict_reg;
    logic        whitelisted_reg;
    logic [31:0] reported_ip_reg;
    logic [55:0] station_id_reg;
    logic        id_valid_reg;
    logic        load_ok_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            verdict_reg     <= verdict;
            whitelisted_reg <= whitelisted;
            reported_ip_reg <= reported_ip;
            station_id_reg  <= station_id;
            id_valid_reg    <= id_valid;
            load_ok_out_reg <= load_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, load_ok_out_reg, station_id_reg, reported_ip_reg,
                       whitelisted_reg};
    assign m_tuser  = {id_valid_reg, verdict_reg};

    // Status
    always_comb begin
        status.is_classify = (req_type_reg == REQ_CLASSIFY);
        status.scan_done   = !rd_vld_reg && ((idx_reg >= scan_cnt) || hit_reg);
        status.out_busy    = out_valid_reg && !m_tready;
    end

    // Checks
    `IPRWL_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, (tcp_cnt_reg <= CNT_W'(N)) && (udp_cnt_reg <= CNT_W'(N)) && (dhcp_cnt_reg <= CNT_W'(N)), "list count above capacity")
    `IPRWL_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.emit, !out_valid_reg || m_tready, "result overwritten before taken")
    `IPRWL_ASSERT_IMP(a_id_udp, aclk, aresetn, out_valid_reg && id_valid_reg, verdict_reg == KIND_UDP, "station id on non-udp verdict")
    `IPRWL_ASSERT_IMP(a_load_quiet, aclk, aresetn, out_valid_reg && load_ok_out_reg, (verdict_reg == KIND_NONE) && !whitelisted_reg && !id_valid_reg, "load result carries packet fields")
    `IPRWL_ASSERT_IMP(a_hit_from_read, aclk, aresetn, $rose(hit_reg), $past(rd_vld_reg), "hit without a range read")

endmodule

@@ sv/ip_range_whitelist_classifier.sv @@
// Top level of the IPv4 range whitelist classifier.
//
//  channel | direction | tdata (low bit up)                        | tuser (low bit up)
//  s_      | request   | list_sel, range_start, range_end, src_ip, | req_type, parse_ok,
//          |           | remote_ip, proto_type, zero pad to 144     | pkt_kind
//  m_      | result    | whitelisted, reported_ip, station_id,      | verdict, id_valid
//          |           | load_ok, zero pad to 96                    |
//
// A classify request scans the list that it checks, one range read a cycle until the fill of
// that list is reached, and a hit ends the scan early. Clear and append requests skip the scan
// reads and apply their change in an execute state.
// Reset clears the list counts and the control state; range entries need no clearing pass.
// A finished result waits in the output register while the next request is taken; a request
// completing while that register is still full holds until the result is taken.
module ip_range_whitelist_classifier #(
    parameter int RANGES_PER_LIST = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // list_sel, range_start, range_end, src_ip, remote_ip, proto_type
    input  logic [iprwl_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type, parse_ok, pkt_kind
    input  logic [iprwl_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // whitelisted, reported_ip, station_id, load_ok
    output logic [iprwl_pkg::M_TDATA_W-1:0]  m_tdata,
    // verdict, id_valid
    output logic [iprwl_pkg::M_TUSER_W-1:0]  m_tuser
);
    import iprwl_pkg::*;

    cmd_t    cmd;
    status_t status;

    iprwl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    iprwl_dp #(
        .N (RANGES_PER_LIST)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ tb/tb_ip_range_whitelist_classifier.sv @@
// Self-checking testbench for the IPv4 range whitelist classifier stream block.
module tb_ip_range_whitelist_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import iprwl_pkg::*;

    localparam int RANGES      = 16;
    localparam int NUM_LISTS   = 3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 40;

    // One request as seen on the slave side
    typedef struct {
        logic [1:0]  req_type;
        logic [1:0]  list_sel;
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic        parse_ok;
        logic [2:0]  pkt_kind;
        logic [31:0] src_ip;
        logic [31:0] remote_ip;
        logic [7:0]  proto_type;
    } req_t;

    // One result as seen on the master side
    typedef struct {
        logic [2:0]  verdict;
        logic        whitelisted;
        logic [31:0] reported_ip;
        logic [55:0] station_id;
        logic        id_valid;
        logic        load_ok;
    } res_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Shadow copy of the three whitelists
    logic [31:0] shadow_lo [NUM_LISTS][RANGES];
    logic [31:0] shadow_hi [NUM_LISTS][RANGES];
    int          shadow_fill [NUM_LISTS];

    res_t expected_results [$];
    int   mismatch_count  = 0;
    int   requests_sent   = 0;
    int   results_checked = 0;
    int   cycle_count     = 0;
    int   send_idle_pct   = 0;
    int   recv_stall_pct  = 0;
    int   hold_cycles     = 0;

    ip_range_whitelist_classifier #(
        .RANGES_PER_LIST(RANGES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Clock
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Cycle limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached, %0d results outstanding", $time,
                     expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Address hit against one shadow list
    function automatic logic list_hit(int sel, logic [31:0] addr);
        for (int i = 0; i < shadow_fill[sel]; i++) begin
            if (addr >= shadow_lo[sel][i] && addr <= shadow_hi[sel][i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Expected result of one request; updates the shadow lists
    function automatic res_t screen_request(req_t r);
        res_t        res;
        int          sel;
        logic [31:0] net;
        res = '{default: '0};
        sel = int'(r.list_sel);
        case (r.req_type)
            REQ_CLEAR: begin
                if (r.list_sel <= LIST_DHCP) begin
                    shadow_fill[sel] = 0;
                    res.load_ok = 1'b1;
                end
            end
            REQ_APPEND: begin
                if (r.list_sel <= LIST_DHCP && shadow_fill[sel] < RANGES) begin
                    shadow_lo[sel][shadow_fill[sel]] = r.range_start;
                    shadow_hi[sel][shadow_fill[sel]] = r.range_end;
                    shadow_fill[sel]++;
                    res.load_ok = 1'b1;
                end
            end
            REQ_CLASSIFY: begin
                if (r.parse_ok) begin
                    case (r.pkt_kind)
                        KIND_TCP: begin
                            if (list_hit(int'(LIST_TCP), r.src_ip)) begin
                                res.whitelisted = 1'b1;
                            end else begin
                                res.verdict     = KIND_TCP;
                                res.reported_ip = r.remote_ip;
                            end
                        end
                        KIND_UDP: begin
                            if (list_hit(int'(LIST_UDP), r.remote_ip)) begin
                                res.whitelisted = 1'b1;
                            end else begin
                                net             = r.remote_ip & UDP_NET_MASK;
                                res.verdict     = KIND_UDP;
                                res.reported_ip = net;
                                res.station_id  = {r.proto_type, net[7:0], net[15:8],
                                                   net[23:16], net[31:24], 16'h0000};
                                res.id_valid    = 1'b1;
                            end
                        end
                        KIND_DHCP: begin
                            if (list_hit(int'(LIST_DHCP), r.remote_ip)) begin
                                res.whitelisted = 1'b1;
                            end else begin
                                res.verdict     = KIND_DHCP;
                                res.reported_ip = r.remote_ip;
                            end
                        end
                        KIND_ARP: begin
                            res.verdict     = KIND_ARP;
                            res.reported_ip = r.remote_ip;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic req_t mk_classify(logic [2:0] kind, logic pok, logic [31:0] sip,
                                         logic [31:0] rip, logic [7:0] ptype);
        req_t r;
        r = '{default: '0};
        r.req_type   = REQ_CLASSIFY;
        r.pkt_kind   = kind;
        r.parse_ok   = pok;
        r.src_ip     = sip;
        r.remote_ip  = rip;
        r.proto_type = ptype;
        return r;
    endfunction

    function automatic req_t mk_load(logic [1:0] req, logic [1:0] sel, logic [31:0] lo,
                                     logic [31:0] hi);
        req_t r;
        r = '{default: '0};
        r.req_type    = req;
        r.list_sel    = sel;
        r.range_start = lo;
        r.range_end   = hi;
        return r;
    endfunction

    // Random request, mostly well-formed, aimed at the current list boundaries
    function automatic req_t gen_request();
        req_t        r;
        int          pick;
        int          sel;
        int          idx;
        logic [31:0] addr;
        r.req_type    = 2'($urandom_range(3));
        r.list_sel    = 2'($urandom_range(3));
        r.range_start = $urandom;
        r.range_end   = $urandom;
        r.parse_ok    = 1'($urandom_range(1));
        r.pkt_kind    = 3'($urandom_range(7));
        r.src_ip      = $urandom;
        r.remote_ip   = $urandom;
        r.proto_type  = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 10) begin
            // noise: every field random
        end else if (pick < 13) begin
            r.req_type = REQ_CLEAR;
            r.list_sel = 2'($urandom_range(2));
        end else if (pick < 38) begin
            r.req_type = REQ_APPEND;
            r.list_sel = 2'($urandom_range(2));
            case ($urandom_range(9))
                0: ;
                1: r.range_end = r.range_start;
                2: r.range_end = r.range_start - 32'($urandom_range(1, 1000));
                default: r.range_end = r.range_start + 32'($urandom_range(65535));
            endcase
        end else begin
            r.req_type = REQ_CLASSIFY;
            r.parse_ok = 1'b1;
            r.pkt_kind = 3'($urandom_range(1, 4));
            case (r.pkt_kind)
                KIND_TCP:  sel = int'(LIST_TCP);
                KIND_UDP:  sel = int'(LIST_UDP);
                KIND_DHCP: sel = int'(LIST_DHCP);
                default:   sel = $urandom_range(2);
            endcase
            // land on or just beside a stored boundary
            if (shadow_fill[sel] > 0 && $urandom_range(3) != 0) begin
                idx  = $urandom_range(shadow_fill[sel] - 1);
                addr = $urandom_range(1) ? shadow_lo[sel][idx] : shadow_hi[sel][idx];
                addr = addr + 32'($urandom_range(2)) - 32'd1;
                if (r.pkt_kind == KIND_TCP)
                    r.src_ip = addr;
                else
                    r.remote_ip = addr;
            end
        end
        return r;
    endfunction

    // Send one request; entered and left just after a rising edge
    task automatic send_request(req_t r);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, r.proto_type, r.remote_ip, r.src_ip, r.range_end,
                     r.range_start, r.list_sel};
        s_tuser  <= {r.pkt_kind, r.parse_ok, r.req_type};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(screen_request(r));
        requests_sent++;
    endtask

    // Stop sending until every expected result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Result channel: random stall or a counted hold-off
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin
        res_t got;
        res_t exp;
        if (aresetn && m_tvalid && m_tready) begin
            got.whitelisted = m_tdata[0];
            got.reported_ip = m_tdata[32:1];
            got.station_id  = m_tdata[88:33];
            got.load_ok     = m_tdata[89];
            got.verdict     = m_tuser[2:0];
            got.id_valid    = m_tuser[3];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result verdict=%0d reported_ip=%h load_ok=%0d",
                         $time, got.verdict, got.reported_ip, got.load_ok);
                mismatch_count++;
            end else begin
                exp = expected_results.pop_front();
                results_checked++;
                if (got.verdict !== exp.verdict) begin
                    $display("%0t: verdict expected %0d got %0d", $time, exp.verdict,
                             got.verdict);
                    mismatch_count++;
                end
                if (got.whitelisted !== exp.whitelisted) begin
                    $display("%0t: whitelisted expected %0d got %0d", $time,
                             exp.whitelisted, got.whitelisted);
                    mismatch_count++;
                end
                if (got.reported_ip !== exp.reported_ip) begin
                    $display("%0t: reported_ip expected %h got %h", $time,
                             exp.reported_ip, got.reported_ip);
                    mismatch_count++;
                end
                if (got.station_id !== exp.station_id) begin
                    $display("%0t: station_id expected %h got %h", $time,
                             exp.station_id, got.station_id);
                    mismatch_count++;
                end
                if (got.id_valid !== exp.id_valid) begin
                    $display("%0t: id_valid expected %0d got %0d", $time, exp.id_valid,
                             got.id_valid);
                    mismatch_count++;
                end
                if (got.load_ok !== exp.load_ok) begin
                    $display("%0t: load_ok expected %0d got %0d", $time, exp.load_ok,
                             got.load_ok);
                    mismatch_count++;
                end
            end
        end
    end

    // Empty lists: every kind, parse failure, unknown codes, field extremes
    task automatic test_empty_lists();
        send_request(mk_classify(KIND_TCP, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00));
        send_request(mk_classify(KIND_UDP, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
        send_request(mk_classify(KIND_UDP, 1'b1, 32'h0000_0000, 32'h0000_0000, 8'h00));
        send_request(mk_classify(KIND_DHCP, 1'b1, 32'h1234_5678, 32'h8765_4321, 8'h5A));
        send_request(mk_classify(KIND_ARP, 1'b1, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'hA5));
        send_request(mk_classify(KIND_TCP, 1'b0, 32'h0101_0101, 32'h0202_0202, 8'h11));
        send_request(mk_classify(KIND_NONE, 1'b1, 32'h0101_0101, 32'h0202_0202, 8'h11));
        send_request(mk_classify(3'd5, 1'b1, 32'h0101_0101, 32'h0202_0202, 8'h11));
        send_request(mk_classify(3'd7, 1'b1, 32'h0101_0101, 32'h0202_0202, 8'h11));
        // unknown request code, unknown list
        send_request(mk_load(2'd3, LIST_TCP, 32'h0, 32'hFFFF_FFFF));
        send_request(mk_load(REQ_CLEAR, 2'd3, 32'h0, 32'h0));
        send_request(mk_load(REQ_APPEND, 2'd3, 32'h0, 32'hFFFF_FFFF));
    endtask

    // Loaded lists: range edges, /24 masking, empty and full ranges, clear
    task automatic test_list_hits();
        send_request(mk_load(REQ_APPEND, LIST_TCP, 32'h0A00_0000, 32'h0A00_00FF));
        send_request(mk_classify(KIND_TCP, 1'b1, 32'h0A00_0000, 32'hC0A8_0001, 8'h06));
        send_request(mk_classify(KIND_TCP, 1'b1, 32'h0A00_00FF, 32'hC0A8_0001, 8'h06));
        send_request(mk_classify(KIND_TCP, 1'b1, 32'h0A00_0100, 32'hC0A8_0001, 8'h06));
        send_request(mk_classify(KIND_TCP, 1'b1, 32'h09FF_FFFF, 32'hC0A8_0001, 8'h06));
        send_request(mk_load(REQ_APPEND, LIST_UDP, 32'hC0A8_0100, 32'hC0A8_01FF));
        send_request(mk_classify(KIND_UDP, 1'b1, 32'h0, 32'hC0A8_0180, 8'h11));
        send_request(mk_classify(KIND_UDP, 1'b1, 32'h0, 32'hC0A8_02FE, 8'h11));
        // start above end never matches
        send_request(mk_load(REQ_APPEND, LIST_DHCP, 32'h0000_0020, 32'h0000_0010));
        send_request(mk_classify(KIND_DHCP, 1'b1, 32'h0, 32'h0000_0018, 8'h43));
        send_request(mk_load(REQ_APPEND, LIST_DHCP, 32'h0000_0000, 32'hFFFF_FFFF));
        send_request(mk_classify(KIND_DHCP, 1'b1, 32'h0, 32'hFFFF_FFFF, 8'h43));
        send_request(mk_classify(KIND_ARP, 1'b1, 32'h0A00_0000, 32'hFFFF_FFFF, 8'h00));
        send_request(mk_load(REQ_CLEAR, LIST_TCP, 32'h0, 32'h0));
        send_request(mk_classify(KIND_TCP, 1'b1, 32'h0A00_0000, 32'hC0A8_0001, 8'h06));
    endtask

    // Clear one list, fill it past capacity, then check the last entry
    task automatic test_full_list();
        logic [31:0] lo;
        send_request(mk_load(REQ_CLEAR, LIST_UDP, 32'h0, 32'h0));
        for (int i = 0; i < RANGES; i++) begin
            lo = $urandom;
            send_request(mk_load(REQ_APPEND, LIST_UDP, lo, lo + 32'h0000_0400));
        end
        send_request(mk_load(REQ_APPEND, LIST_UDP, 32'h0, 32'hFFFF_FFFF));
        send_request(mk_classify(KIND_UDP, 1'b1, 32'h0, lo + 32'h0000_0200, 8'h22));
        send_request(mk_classify(KIND_UDP, 1'b1, 32'h0, lo + 32'h0000_0401, 8'h22));
        drain_results();
    endtask

    // Receiver holds off while the sender keeps offering requests
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 400;
        for (int i = 0; i < 40; i++)
            send_request(gen_request());
        drain_results();
    endtask

    task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            send_request(gen_request());
        drain_results();
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        for (int l = 0; l < NUM_LISTS; l++)
            shadow_fill[l] = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_lists();
        test_list_hits();
        drain_results();
        test_full_list();
        test_backpressure();
        test_random_traffic(440, 0, 0);
        test_random_traffic(440, 61, 0);
        test_random_traffic(440, 0, 61);
        test_random_traffic(440, 32, 32);

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            mismatch_count++;
        end

        $display("Covered %0d requests (clear, append, full list, classify of all kinds)",
                 requests_sent);
        $display("and %0d checked results under idle, stall and hold-off phases.",
                 results_checked);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
